[src/frustum_box_cull_macros.svh]
// Assertion macros for the frustum box cull block.
`ifndef FRUSTUM_BOX_CULL_MACROS_SVH
`define FRUSTUM_BOX_CULL_MACROS_SVH

`ifndef SYNTHESIS

// The condition must never hold outside reset.
`define FBC_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("frustum_box_cull: forbidden condition seen");

// When the antecedent holds, the consequent must hold in the next cycle.
`define FBC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frustum_box_cull: sequence check failed");

// When the antecedent holds, the consequent must hold in the same cycle.
`define FBC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frustum_box_cull: implication check failed");

`else

`define FBC_ASSERT_NEVER(lbl, cond)
`define FBC_ASSERT_NEXT(lbl, ante, cons)
`define FBC_ASSERT_IMPL(lbl, ante, cons)

`endif

`endif

[src/fbc_pkg.sv]
// Shared types and constants for the frustum box cull block.
package fbc_pkg;

  localparam int NUM_PLANES  = 6;
  localparam int NUM_COEFFS  = 4;
  localparam int NUM_ENTRIES = NUM_PLANES * NUM_COEFFS;

  localparam int COORD_W = 32;
  localparam int COEFF_W = COORD_W + 1;
  localparam int PROD_W  = COEFF_W + COORD_W;
  localparam int ACC_W   = PROD_W + 2;
  localparam int CONST_SHIFT = 16;

  localparam int IDX_W = $clog2(NUM_ENTRIES);

  // Last entry of the sweep: far plane, constant term.
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ENTRIES - 1);

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_TEST = 1'b1;

  localparam logic [1:0] COEFF_CONST = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_FINISH
  } state_t;

  // Control travelling with each term into the multiply-accumulate unit.
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } mac_ctl_t;

  // Per-plane outcome from the multiply-accumulate unit.
  typedef struct packed {
    logic vld;
    logic neg;
  } plane_res_t;

endpackage

[src/frustum_box_cull.sv]
// Top level of the frustum box cull block: plane store, sequencer and result register.
//
// The block keeps the six clip planes (left, right, bottom, top, near, far) of a
// view-projection matrix and tests axis-aligned boxes against them. An item with
// mode 0 loads one matrix column: all six planes take their coefficient for that
// column in the cycle of acceptance, no result is produced and the block is ready
// again at once. An item with mode 1 tests a box: for each plane the positive
// vertex is chosen and the exact signed distance in Q32.32 is formed, and one
// result item reports visible unless some distance is negative. All values are
// signed Q16.16. A box test runs through the 24 plane coefficients one per cycle
// on a single 33 by 32 bit multiplier feeding a 67 bit accumulator, so the input
// side is stalled after a box is accepted, through the term sweep, the drain of
// the accumulator and the hand-over of the result; the result is registered at
// the hand-over and waits in the output register while the next item is taken.
// If the previous result has not yet been taken, the hand-over cycle is held
// until it has. After reset all coefficients are zero, so every box reads as
// visible until planes are loaded.
module frustum_box_cull
  import fbc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_mode,
  input  logic [1:0]                in_column_index,
  input  logic signed [COORD_W-1:0] in_col_row0,
  input  logic signed [COORD_W-1:0] in_col_row1,
  input  logic signed [COORD_W-1:0] in_col_row2,
  input  logic signed [COORD_W-1:0] in_col_row3,
  input  logic signed [COORD_W-1:0] in_box_min_x,
  input  logic signed [COORD_W-1:0] in_box_min_y,
  input  logic signed [COORD_W-1:0] in_box_min_z,
  input  logic signed [COORD_W-1:0] in_box_max_x,
  input  logic signed [COORD_W-1:0] in_box_max_y,
  input  logic signed [COORD_W-1:0] in_box_max_z,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_visible
);

  `include "frustum_box_cull_macros.svh"

  state_t                    state_r, state_nxt;
  logic [IDX_W-1:0]          idx_r, idx_nxt;
  logic                      neg_r, neg_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic                      out_visible_r, out_visible_nxt;
  logic                      take;

  // Plane store, entry index is {plane, coefficient}.
  logic signed [COEFF_W-1:0] coeff_r [NUM_ENTRIES];
  logic signed [COORD_W-1:0] box_lo_r [3];
  logic signed [COORD_W-1:0] box_hi_r [3];
  logic signed [COORD_W-1:0] col_rows [3];

  mac_ctl_t                  mac_ctl;
  plane_res_t                mac_res;
  logic signed [COEFF_W-1:0] cur_coeff;
  logic signed [COORD_W-1:0] cur_coord;

  assign in_stall    = (state_r != S_IDLE);
  assign take        = in_valid & ~in_stall;
  assign out_valid   = out_valid_r;
  assign out_visible = out_visible_r;

  assign col_rows[0] = in_col_row0;
  assign col_rows[1] = in_col_row1;
  assign col_rows[2] = in_col_row2;

  // A column load writes its coefficient in all six planes. Even planes add the
  // row to row 3, odd planes subtract it; each result fits in 33 bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int e = 0; e < NUM_ENTRIES; e++) begin
        coeff_r[e] <= '0;
      end
    end else if (take && in_mode == MODE_LOAD) begin
      for (int p = 0; p < NUM_PLANES; p++) begin
        if (p % 2 == 0) begin
          coeff_r[{3'(p), in_column_index}] <=
            COEFF_W'(in_col_row3) + COEFF_W'(col_rows[p / 2]);
        end else begin
          coeff_r[{3'(p), in_column_index}] <=
            COEFF_W'(in_col_row3) - COEFF_W'(col_rows[p / 2]);
        end
      end
    end
  end

  // The box corners are held for the length of the sweep.
  always_ff @(posedge clk) begin
    if (take && in_mode == MODE_TEST) begin
      box_lo_r[0] <= in_box_min_x;
      box_lo_r[1] <= in_box_min_y;
      box_lo_r[2] <= in_box_min_z;
      box_hi_r[0] <= in_box_max_x;
      box_hi_r[1] <= in_box_max_y;
      box_hi_r[2] <= in_box_max_z;
    end
  end

  // Positive vertex: the maximum where the coefficient is non-negative, else the
  // minimum. The constant term needs no coordinate.
  assign cur_coeff = coeff_r[idx_r];

  always_comb begin
    case (idx_r[1:0])
      2'd0:    cur_coord = cur_coeff[COEFF_W-1] ? box_lo_r[0] : box_hi_r[0];
      2'd1:    cur_coord = cur_coeff[COEFF_W-1] ? box_lo_r[1] : box_hi_r[1];
      2'd2:    cur_coord = cur_coeff[COEFF_W-1] ? box_lo_r[2] : box_hi_r[2];
      default: cur_coord = '0;
    endcase
  end

  assign mac_ctl.vld   = (state_r == S_RUN);
  assign mac_ctl.first = (idx_r[1:0] == 2'd0);
  assign mac_ctl.last  = (idx_r[1:0] == COEFF_CONST);

  fbc_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .coeff (cur_coeff),
    .coord (cur_coord),
    .res   (mac_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      idx_r         <= '0;
      neg_r         <= 1'b0;
      out_valid_r   <= 1'b0;
      out_visible_r <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      idx_r         <= idx_nxt;
      neg_r         <= neg_nxt;
      out_valid_r   <= out_valid_nxt;
      out_visible_r <= out_visible_nxt;
    end
  end

  // Sequencer. The sweep issues one term per cycle; the last plane's distance
  // settles during the drain cycle, after which the verdict is complete.
  always_comb begin
    state_nxt       = state_r;
    idx_nxt         = idx_r;
    neg_nxt         = neg_r | (mac_res.vld & mac_res.neg);
    out_valid_nxt   = out_valid_r;
    out_visible_nxt = out_visible_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (take && in_mode == MODE_TEST) begin
          state_nxt = S_RUN;
          idx_nxt   = '0;
          neg_nxt   = 1'b0;
        end
      end
      S_RUN: begin
        if (idx_r == LAST_IDX) begin
          state_nxt = S_DRAIN;
          idx_nxt   = '0;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_DRAIN: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt   = 1'b1;
          out_visible_nxt = ~neg_r;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // A new result is only ever raised from the hand-over state.
  `FBC_ASSERT_IMPL(a_result_from_finish, $rose(out_valid_r), $past(state_r) == S_FINISH)
  // A result that is still waiting holds the hand-over state.
  `FBC_ASSERT_NEXT(a_finish_holds, state_r == S_FINISH && out_valid_r && out_stall, state_r == S_FINISH)
  // The sweep index always restarts from the first entry.
  `FBC_ASSERT_NEVER(a_idle_idx_zero, state_r != S_RUN && idx_r != '0)
  // The unit reports a plane distance only while the sweep or its drain runs.
  `FBC_ASSERT_NEVER(a_res_in_sweep, mac_res.vld && (state_r == S_IDLE || state_r == S_FINISH))

endmodule

[src/fbc_mac.sv]
// Shared multiply-accumulate unit that forms one plane distance term by term.
module fbc_mac
  import fbc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  mac_ctl_t                  ctl,
  input  logic signed [COEFF_W-1:0] coeff,
  input  logic signed [COORD_W-1:0] coord,
  output plane_res_t                res
);

  logic signed [PROD_W-1:0] term_nxt;
  logic signed [PROD_W-1:0] term_r;
  mac_ctl_t                 ctl_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_base;
  logic signed [ACC_W-1:0]  sum;

  // The constant term is shifted up to Q32.32; the others are exact products.
  always_comb begin
    if (ctl.last) begin
      term_nxt = PROD_W'(coeff) <<< CONST_SHIFT;
    end else begin
      term_nxt = PROD_W'(coeff) * PROD_W'(coord);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl;
    end
  end

  always_ff @(posedge clk) begin
    term_r <= term_nxt;
  end

  assign acc_base = ctl_r.first ? '0 : acc_r;
  assign sum      = acc_base + ACC_W'(term_r);

  always_ff @(posedge clk) begin
    if (ctl_r.vld) begin
      acc_r <= sum;
    end
  end

  assign res.vld = ctl_r.vld & ctl_r.last;
  assign res.neg = sum[ACC_W-1];

endmodule

[tb/sv/frustum_box_cull_tb.sv]
// Self-checking testbench for the frustum box cull block: directed and random items with scoreboard.
module frustum_box_cull_tb;
  import fbc_pkg::*;

  // Row 3 of a matrix column carries the w term of every plane.
  localparam int W_ROW = 3;
  // One bit more than the block's accumulator, so the predicted distance can never wrap.
  localparam int DIST_W = ACC_W + 1;
  // Cycles with no handshake on either side before the run is declared hung. The limit
  // allows for a whole box test as well as long random stalls and sender gaps.
  localparam int QUIET_LIMIT = 2000;
  // Cycles allowed after the last expected result for any stray result to show itself.
  localparam int DRAIN_CYCLES = 40;
  localparam int SHOW_LIMIT = 10;
  localparam int PHASE_ITEMS = 617;

  localparam logic [COORD_W-1:0] Q_MAX = 32'h7fff_ffff;
  localparam logic [COORD_W-1:0] Q_MIN = 32'h8000_0000;
  localparam logic [COORD_W-1:0] Q_ONE = 32'h0001_0000;
  localparam logic [COORD_W-1:0] Q_HALF = 32'h0000_8000;
  localparam logic [COORD_W-1:0] Q_NEG_HALF = 32'hffff_8000;
  localparam logic [COORD_W-1:0] Q_NEG_ONE = 32'hffff_0000;

  // Value ranges used when building random rows and box corners.
  typedef enum int {
    SPAN_FULL,
    SPAN_NEAR,
    SPAN_WIDE,
    SPAN_EDGE
  } span_t;

  // Everything one input item carries, whether the block uses it or not.
  typedef struct packed {
    logic                    mode;
    logic [1:0]              column;
    logic [3:0][COORD_W-1:0] row;
    logic [2:0][COORD_W-1:0] lo;
    logic [2:0][COORD_W-1:0] hi;
  } cull_item_t;

  // Scoreboard: keeps its own copy of the six planes and a queue of the visibility
  // verdicts still owed by the block, oldest first.
  class cull_scoreboard;
    logic signed [COEFF_W-1:0] plane_coeff [NUM_ENTRIES];
    bit visible_due [$];
    int fail_count;
    int results_seen;

    function new();
      foreach (plane_coeff[i]) plane_coeff[i] = '0;
      fail_count = 0;
      results_seen = 0;
    endfunction

    // A column load rewrites one coefficient of every plane; a box test queues its verdict.
    function void note_item(cull_item_t it);
      logic signed [COEFF_W-1:0] w_row;
      logic signed [COEFF_W-1:0] r_row;
      logic signed [DIST_W-1:0]  distance;
      logic signed [DIST_W-1:0]  coef;
      logic signed [DIST_W-1:0]  coord;
      bit vis;
      int p;
      int k;
      if (it.mode == MODE_LOAD) begin
        w_row = $signed(it.row[W_ROW]);
        for (p = 0; p < NUM_PLANES; p++) begin
          r_row = $signed(it.row[p / 2]);
          plane_coeff[p * NUM_COEFFS + it.column] = (p % 2 == 0) ? w_row + r_row
                                                                   : w_row - r_row;
        end
      end else begin
        vis = 1'b1;
        for (p = 0; p < NUM_PLANES; p++) begin
          coef = plane_coeff[p * NUM_COEFFS + COEFF_CONST];
          distance = coef <<< CONST_SHIFT;
          for (k = 0; k < 3; k++) begin
            coef = plane_coeff[p * NUM_COEFFS + k];
            coord = (coef >= 0) ? $signed(it.hi[k]) : $signed(it.lo[k]);
            distance = distance + coef * coord;
          end
          if (distance < 0) vis = 1'b0;
        end
        visible_due.push_back(vis);
      end
    endfunction

    function void check_result(logic vis);
      bit want;
      results_seen++;
      if (visible_due.size() == 0) begin
        fail_count++;
        if (fail_count <= SHOW_LIMIT)
          $display("result %0d: visible=%b arrived with no box test outstanding",
                   results_seen, vis);
      end else begin
        want = visible_due.pop_front();
        if (vis !== want) begin
          fail_count++;
          if (fail_count <= SHOW_LIMIT)
            $display("result %0d: visible expected %b, got %b", results_seen, want, vis);
        end
      end
    endfunction

    function int pending();
      return visible_due.size();
    endfunction
  endclass

  logic                      clk;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic                      in_mode = 1'b0;
  logic [1:0]                in_column_index = '0;
  logic signed [COORD_W-1:0] in_col_row0 = '0;
  logic signed [COORD_W-1:0] in_col_row1 = '0;
  logic signed [COORD_W-1:0] in_col_row2 = '0;
  logic signed [COORD_W-1:0] in_col_row3 = '0;
  logic signed [COORD_W-1:0] in_box_min_x = '0;
  logic signed [COORD_W-1:0] in_box_min_y = '0;
  logic signed [COORD_W-1:0] in_box_min_z = '0;
  logic signed [COORD_W-1:0] in_box_max_x = '0;
  logic signed [COORD_W-1:0] in_box_max_y = '0;
  logic signed [COORD_W-1:0] in_box_max_z = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic                      out_visible;

  cull_scoreboard sb = new();
  int send_idle_pct = 34;
  int recv_idle_pct = 71;
  int items_sent = 0;
  int quiet_cycles = 0;

  frustum_box_cull u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_column_index (in_column_index),
    .in_col_row0     (in_col_row0),
    .in_col_row1     (in_col_row1),
    .in_col_row2     (in_col_row2),
    .in_col_row3     (in_col_row3),
    .in_box_min_x    (in_box_min_x),
    .in_box_min_y    (in_box_min_y),
    .in_box_min_z    (in_box_min_z),
    .in_box_max_x    (in_box_max_x),
    .in_box_max_y    (in_box_max_y),
    .in_box_max_z    (in_box_max_z),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_visible     (out_visible)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The receiver stalls at random in the share of cycles that the current phase sets.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Both handshakes are sampled at the clock edge, so they see exactly what the block
  // sees. An accepted input is handed to the predictor; an accepted result is checked.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        sb.note_item({in_mode, in_column_index,
                      {in_col_row3, in_col_row2, in_col_row1, in_col_row0},
                      {in_box_min_z, in_box_min_y, in_box_min_x},
                      {in_box_max_z, in_box_max_y, in_box_max_x}});
      end
      if (out_valid && !out_stall) begin
        sb.check_result(out_visible);
      end
    end
  end

  // Watchdog: the run is hung if neither channel moves an item for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Fields that the block ignores for a given mode are still filled with random bits.
  function automatic cull_item_t blank_item();
    cull_item_t it;
    it.mode = 1'($urandom);
    it.column = 2'($urandom);
    for (int k = 0; k < 4; k++) it.row[k] = $urandom;
    for (int k = 0; k < 3; k++) begin
      it.lo[k] = $urandom;
      it.hi[k] = $urandom;
    end
    return it;
  endfunction

  function automatic logic [COORD_W-1:0] rand_coord(span_t span);
    logic [COORD_W-1:0] v;
    case (span)
      SPAN_NEAR: v = COORD_W'($urandom_range(0, 2 ** 19)) - COORD_W'(2 ** 18);
      SPAN_WIDE: v = COORD_W'($urandom_range(0, 2 ** 25)) - COORD_W'(2 ** 24);
      SPAN_EDGE: begin
        case ($urandom_range(4))
          0: v = Q_MIN;
          1: v = Q_MAX;
          2: v = '0;
          3: v = '1;
          default: v = Q_ONE;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Offer one item, after a random gap, and hold it until the block takes it. The task
  // returns in the time step of acceptance, so the next call changes valid only once.
  task automatic send_item(cull_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_mode         <= it.mode;
    in_column_index <= it.column;
    in_col_row0     <= it.row[0];
    in_col_row1     <= it.row[1];
    in_col_row2     <= it.row[2];
    in_col_row3     <= it.row[3];
    in_box_min_x    <= it.lo[0];
    in_box_min_y    <= it.lo[1];
    in_box_min_z    <= it.lo[2];
    in_box_max_x    <= it.hi[0];
    in_box_max_y    <= it.hi[1];
    in_box_max_z    <= it.hi[2];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic drive_load(logic [1:0] column, logic [COORD_W-1:0] r0,
                            logic [COORD_W-1:0] r1, logic [COORD_W-1:0] r2,
                            logic [COORD_W-1:0] r3);
    cull_item_t it;
    it = blank_item();
    it.mode = MODE_LOAD;
    it.column = column;
    it.row = {r3, r2, r1, r0};
    send_item(it);
  endtask

  task automatic drive_test(logic [COORD_W-1:0] lx, logic [COORD_W-1:0] ly,
                            logic [COORD_W-1:0] lz, logic [COORD_W-1:0] hx,
                            logic [COORD_W-1:0] hy, logic [COORD_W-1:0] hz);
    cull_item_t it;
    it = blank_item();
    it.mode = MODE_TEST;
    it.lo = {lz, ly, lx};
    it.hi = {hz, hy, hx};
    send_item(it);
  endtask

  // Random box: mostly ordered corners for the narrower spans, occasionally inverted.
  task automatic drive_random_box(span_t span);
    logic [COORD_W-1:0] lo [3];
    logic [COORD_W-1:0] hi [3];
    logic [COORD_W-1:0] t;
    for (int k = 0; k < 3; k++) begin
      lo[k] = rand_coord(span);
      hi[k] = rand_coord(span);
      if (span != SPAN_FULL && $urandom_range(9) != 0 && $signed(lo[k]) > $signed(hi[k])) begin
        t = lo[k];
        lo[k] = hi[k];
        hi[k] = t;
      end
    end
    drive_test(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
  endtask

  // Random part of one phase. Most of it is a whole matrix followed by a few box tests,
  // which is how the block is really used; the rest is partial loads and pure noise.
  task automatic run_random(int count);
    int stop;
    int pick;
    span_t mspan;
    logic [COORD_W-1:0] r3;
    stop = items_sent + count;
    while (items_sent < stop) begin
      pick = $urandom_range(9);
      if (pick < 7) begin
        mspan = span_t'($urandom_range(3));
        for (int c = 0; c < NUM_COEFFS; c++) begin
          // A large positive w in the constant column gives a frustum that encloses the
          // origin, so small boxes tend to be visible and large ones not.
          if (mspan == SPAN_NEAR && c == W_ROW)
            r3 = COORD_W'($urandom_range(2 ** 20, 2 ** 24));
          else
            r3 = rand_coord(mspan);
          drive_load(2'(c), rand_coord(mspan), rand_coord(mspan), rand_coord(mspan), r3);
        end
        repeat ($urandom_range(1, 5)) drive_random_box(span_t'($urandom_range(3)));
      end else if (pick == 7) begin
        repeat ($urandom_range(1, 2))
          drive_load(2'($urandom), $urandom, $urandom, $urandom, $urandom);
      end else begin
        repeat ($urandom_range(1, 3)) send_item(blank_item());
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Nothing loaded yet: every distance is zero, so any box is visible, including an
    // inverted one.
    drive_test(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX);
    drive_test(Q_MAX, Q_ONE, Q_MAX, Q_MIN, Q_NEG_ONE, Q_MIN);

    // All rows at the maximum: the left, bottom and near coefficients reach their largest
    // value and the other three are zero, which picks the max corner.
    for (int c = 0; c < NUM_COEFFS; c++) drive_load(2'(c), Q_MAX, Q_MAX, Q_MAX, Q_MAX);
    drive_test(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX);
    drive_test(Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN);

    // Mixed extremes: coefficients reach the most negative value and the widest products.
    for (int c = 0; c < NUM_COEFFS; c++) drive_load(2'(c), Q_MIN, Q_MAX, Q_MIN, Q_MIN);
    drive_test(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX);
    drive_test(Q_MIN, Q_MAX, Q_MIN, Q_MIN, Q_MAX, Q_MIN);

    // Identity matrix: the planes are the unit cube.
    drive_load(2'd0, Q_ONE, '0, '0, '0);
    drive_load(2'd1, '0, Q_ONE, '0, '0);
    drive_load(2'd2, '0, '0, Q_ONE, '0);
    drive_load(2'd3, '0, '0, '0, Q_ONE);
    drive_test(Q_NEG_HALF, Q_NEG_HALF, Q_NEG_HALF, Q_HALF, Q_HALF, Q_HALF);
    drive_test(32'h0002_0000, '0, '0, 32'h0003_0000, Q_HALF, Q_HALF);
    drive_test(Q_HALF, Q_NEG_HALF, Q_NEG_HALF, 32'h0003_0000, Q_HALF, Q_HALF);
    drive_test(Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE);

    // Partial load: only the constant column changes, to w = -1, so every plane now has a
    // negative offset while the normals are kept from the identity.
    drive_load(2'd3, '0, '0, '0, Q_NEG_ONE);
    drive_test(Q_NEG_HALF, Q_NEG_HALF, Q_NEG_HALF, Q_HALF, Q_HALF, Q_HALF);
    drive_test('0, '0, '0, '0, '0, '0);

    // Random part in three phases of idling: receiver-heavy, sender-heavy, then none.
    run_random(PHASE_ITEMS);
    send_idle_pct = 71;
    recv_idle_pct = 34;
    run_random(PHASE_ITEMS);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(PHASE_ITEMS);

    // The last item was accepted in this time step; drop valid and let results drain.
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
